### rtl/watchdog_multi_reload_macros.svh
// Assertion macros shared by the watchdog RTL.
`ifndef WATCHDOG_MULTI_RELOAD_MACROS_SVH
`define WATCHDOG_MULTI_RELOAD_MACROS_SVH
`ifndef NO_ASSERTIONS
// Expression must hold at every clock edge outside reset.
`define WDR_ASSERT_NOW(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("watchdog assertion failed");
// Antecedent implies consequent in the same cycle.
`define WDR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("watchdog assertion failed");
// Antecedent implies consequent in the next cycle.
`define WDR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("watchdog assertion failed");
`else
`define WDR_ASSERT_NOW(label, expr)
`define WDR_ASSERT_IMP(label, ante, cons)
`define WDR_ASSERT_NXT(label, ante, cons)
`endif
`endif

### rtl/wdr_pkg.sv
// Types and constants of the multi-channel reload watchdog.
package wdr_pkg;

  localparam int CHANNELS = 8;
  localparam int MASK_W   = 8;
  localparam int COUNT_W  = 32;
  localparam int CHAN_W   = 4;
  localparam int MODE_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] FEED_MAGIC = 32'h6E52_4635;
  localparam logic [MASK_W-1:0]  CHAN_MASK  = MASK_W'((16'd1 << CHANNELS) - 16'd1);

  // Item function codes
  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_FEED   = 2'd2,
    FUNC_STATUS = 2'd3
  } func_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RELOAD_VALUE   = 2'd0,
    REG_CHANNEL_ENABLE = 2'd1,
    REG_RUN_MODES      = 2'd2,
    REG_UNUSED         = 2'd3
  } cfg_idx_t;

  // Run mode bits
  localparam int MODE_SLEEP_BIT = 0;
  localparam int MODE_HALT_BIT  = 3;

  // Reset values of the registers
  localparam logic [COUNT_W-1:0] RELOAD_RESET = 32'hFFFF_FFFF;
  localparam logic [MASK_W-1:0]  ENABLE_RESET = 8'h01;
  localparam logic [MODE_W-1:0]  MODES_RESET  = 4'h1;

  // One result word
  typedef struct packed {
    logic               timeout;
    logic               running;
    logic [MASK_W-1:0]  pending_mask;
    logic               channel_pending;
    logic [COUNT_W-1:0] count_value;
  } result_t;

endpackage

### rtl/wdr_in_if.sv
// Input item channel of the watchdog.
interface wdr_in_if;
  logic                        valid;
  logic                        ready;
  wdr_pkg::func_t              func;
  logic [wdr_pkg::CHAN_W-1:0]  channel;
  logic [wdr_pkg::COUNT_W-1:0] write_word;
  logic                        cpu_sleeping;
  logic                        cpu_halted;

  modport source (output valid, func, channel, write_word, cpu_sleeping, cpu_halted,
                  input ready);
  modport sink   (input valid, func, channel, write_word, cpu_sleeping, cpu_halted,
                  output ready);
endinterface

### rtl/wdr_out_if.sv
// Result channel of the watchdog.
interface wdr_out_if;
  logic                        valid;
  logic                        ready;
  logic                        timeout;
  logic                        running;
  logic [wdr_pkg::MASK_W-1:0]  pending_mask;
  logic                        channel_pending;
  logic [wdr_pkg::COUNT_W-1:0] count_value;

  modport source (output valid, timeout, running, pending_mask, channel_pending,
                  count_value, input ready);
  modport sink   (input valid, timeout, running, pending_mask, channel_pending,
                  count_value, output ready);
endinterface

### rtl/wdr_cfg_if.sv
// Configuration write channel of the watchdog.
interface wdr_cfg_if;
  logic                          valid;
  logic                          ready;
  wdr_pkg::cfg_idx_t             index;
  logic [wdr_pkg::COUNT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/watchdog_multi_reload.sv
// Watchdog timer with several reload request channels, top level.
//
//   channel  dir  handshake      word
//   req      in   valid/ready    func, channel, write_word, cpu_sleeping, cpu_halted
//   rsp      out  valid/ready    timeout, running, pending_mask, channel_pending,
//                                count_value
//   cfg      in   valid/ready    index, data (always ready, locked while running)
//
// One item per clock while req is ready: state updates on the accepting edge, the
// result word goes to the output register, or to the skid entry while rsp stalls.
// A two-entry output buffer (output register plus skid) keeps req ready while
// one result waits; req.ready drops only when both entries are full.
// rst is synchronous, active high: stopped, counter and pending bits zero,
// registers at their reset values, output buffer empty.
module watchdog_multi_reload (
  input  logic       clk,
  input  logic       rst,
  wdr_in_if.sink     req,
  wdr_out_if.source  rsp,
  wdr_cfg_if.sink    cfg
);
  import wdr_pkg::*;
  `include "watchdog_multi_reload_macros.svh"

  // Configuration registers
  logic [COUNT_W-1:0] reload_value;
  logic [MASK_W-1:0]  channel_enable;
  logic [MODE_W-1:0]  run_modes;

  // Watchdog state
  logic [COUNT_W-1:0] down_count, down_count_next;
  logic [MASK_W-1:0]  pending_bits, pending_bits_next;
  logic               running, running_next;

  // Output buffer
  result_t out_word, skid_word, result_c;
  logic    out_valid, skid_valid;

  logic accept, pop;
  logic [MASK_W-1:0] en_mask, chan_bit, pend_clr;
  logic chan_ok, blocked, feed_hit, timeout_c;

  assign accept  = req.valid && req.ready;
  assign pop     = out_valid && rsp.ready;
  assign en_mask = channel_enable & CHAN_MASK;
  assign chan_ok = req.channel < CHAN_W'(CHANNELS);
  assign chan_bit = MASK_W'(1) << req.channel[2:0];
  assign pend_clr = pending_bits & ~chan_bit;

  // Configuration writes, ignored once running
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value   <= RELOAD_RESET;
      channel_enable <= ENABLE_RESET;
      run_modes      <= MODES_RESET;
    end else if (cfg.valid && !running) begin
      unique case (cfg.index)
        REG_RELOAD_VALUE:   reload_value   <= cfg.data;
        REG_CHANNEL_ENABLE: channel_enable <= cfg.data[MASK_W-1:0];
        REG_RUN_MODES:      run_modes      <= cfg.data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state for the presented item
  always_comb begin
    down_count_next   = down_count;
    pending_bits_next = pending_bits;
    running_next      = running;
    timeout_c         = 1'b0;
    blocked  = (req.cpu_sleeping && !run_modes[MODE_SLEEP_BIT]) ||
               (req.cpu_halted && !run_modes[MODE_HALT_BIT]);
    feed_hit = running && chan_ok && (req.write_word == FEED_MAGIC) &&
               ((en_mask & pending_bits & chan_bit) != '0);
    unique case (req.func)
      FUNC_START: begin
        if (!running) begin
          down_count_next   = reload_value;
          pending_bits_next = en_mask;
          running_next      = 1'b1;
        end
      end
      FUNC_TICK: begin
        if (running && !blocked) begin
          if (down_count <= COUNT_W'(1)) begin
            timeout_c         = 1'b1;
            down_count_next   = reload_value;
            pending_bits_next = en_mask;
          end else begin
            down_count_next = down_count - COUNT_W'(1);
          end
        end
      end
      FUNC_FEED: begin
        if (feed_hit) begin
          if (pend_clr == '0) begin
            down_count_next   = reload_value;
            pending_bits_next = en_mask;
          end else begin
            pending_bits_next = pend_clr;
          end
        end
      end
      default: ;
    endcase
  end

  // Result word
  always_comb begin
    result_c.timeout         = timeout_c;
    result_c.running         = running_next;
    result_c.pending_mask    = pending_bits_next;
    result_c.channel_pending = chan_ok && pending_bits_next[req.channel[2:0]];
    result_c.count_value     = down_count_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      down_count   <= '0;
      pending_bits <= '0;
      running      <= 1'b0;
    end else if (accept) begin
      down_count   <= down_count_next;
      pending_bits <= pending_bits_next;
      running      <= running_next;
    end
  end

  // Output register and skid entry
  assign req.ready = !skid_valid;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
        out_valid  <= 1'b1;
      end else begin
        out_valid <= accept;
        if (accept) out_word <= result_c;
      end
    end else if (accept) begin
      skid_word  <= result_c;
      skid_valid <= 1'b1;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.timeout         = out_word.timeout;
  assign rsp.running         = out_word.running;
  assign rsp.pending_mask    = out_word.pending_mask;
  assign rsp.channel_pending = out_word.channel_pending;
  assign rsp.count_value     = out_word.count_value;

  // Checks
  `WDR_ASSERT_IMP(a_skid_behind_out, skid_valid, out_valid)
  `WDR_ASSERT_IMP(a_timeout_running, out_valid && out_word.timeout, out_word.running)
  `WDR_ASSERT_NOW(a_pending_in_mask, (pending_bits & ~CHAN_MASK) == '0)
  `WDR_ASSERT_NXT(a_stays_running, running, running)
  `WDR_ASSERT_NXT(a_start_loads, accept && req.func == FUNC_START && !running,
                  running && down_count == $past(reload_value))

endmodule

### test/watchdog_multi_reload_test.sv
// Testbench of the multi-channel reload watchdog: scoreboard, stimulus and checks.
module watchdog_multi_reload_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wdr_pkg::*;

  localparam int RANDOM_WORDS = 800;
  localparam int HOLD_CYCLES  = 80;
  localparam int QUIET_LIMIT  = 2000;
  localparam int SHOWN_ERRORS = 10;

  // Watchdog shadow: registers, counter, pending bits and the queue of predicted results
  class wdog_scoreboard;
    logic [COUNT_W-1:0] reload_val;
    logic [MASK_W-1:0]  enable_bits;
    logic [MODE_W-1:0]  mode_bits;
    logic [COUNT_W-1:0] count;
    logic [MASK_W-1:0]  pending;
    bit                 running;
    result_t            expected_q[$];
    int mismatches;
    int words_in;
    int words_out;
    int timeouts;
    int feed_reloads;
    int reg_writes;

    function new();
      reload_val   = RELOAD_RESET;
      enable_bits  = ENABLE_RESET;
      mode_bits    = MODES_RESET;
      count        = '0;
      pending      = '0;
      running      = 1'b0;
      mismatches   = 0;
      words_in     = 0;
      words_out    = 0;
      timeouts     = 0;
      feed_reloads = 0;
      reg_writes   = 0;
    endfunction

    // Registers are locked once the watchdog runs
    function void write_reg(cfg_idx_t idx, logic [COUNT_W-1:0] d);
      reg_writes++;
      if (running) return;
      case (idx)
        REG_RELOAD_VALUE:   reload_val = d;
        REG_CHANNEL_ENABLE: enable_bits = d[MASK_W-1:0];
        REG_RUN_MODES:      mode_bits = d[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    function void rearm();
      count   = reload_val;
      pending = enable_bits & CHAN_MASK;
    endfunction

    // Update the shadow for one accepted word and queue the result it causes
    function void note_item(func_t f, logic [CHAN_W-1:0] ch, logic [COUNT_W-1:0] w,
                            logic sl, logic ha);
      result_t           r;
      logic [MASK_W-1:0] bitm;
      logic              blocked;
      logic              chan_ok;
      r = '0;
      chan_ok = (ch < CHANNELS);
      words_in++;
      case (f)
        FUNC_START: begin
          if (!running) begin
            rearm();
            running = 1'b1;
          end
        end
        FUNC_TICK: begin
          if (running) begin
            blocked = (sl && !mode_bits[MODE_SLEEP_BIT]) || (ha && !mode_bits[MODE_HALT_BIT]);
            if (!blocked) begin
              if (count <= 1) begin
                r.timeout = 1'b1;
                timeouts++;
                rearm();
              end else begin
                count = count - 1;
              end
            end
          end
        end
        FUNC_FEED: begin
          if (running && chan_ok && w == FEED_MAGIC) begin
            bitm = MASK_W'(1) << ch;
            if ((enable_bits & CHAN_MASK & bitm) != 0 && (pending & bitm) != 0) begin
              pending = pending & ~bitm;
              // last enabled channel fed: reload and arm again
              if (pending == 0) begin
                feed_reloads++;
                rearm();
              end
            end
          end
        end
        default: ;
      endcase
      r.running         = running;
      r.pending_mask    = pending;
      r.channel_pending = chan_ok ? pending[ch[2:0]] : 1'b0;
      r.count_value     = count;
      expected_q.push_back(r);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(result_t got);
      result_t exp_w;
      words_out++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("ERROR: result word with nothing predicted: count=%08h", got.count_value);
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.timeout !== exp_w.timeout || got.running !== exp_w.running ||
          got.pending_mask !== exp_w.pending_mask ||
          got.channel_pending !== exp_w.channel_pending ||
          got.count_value !== exp_w.count_value) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS) begin
          $display("ERROR: word %0d expected timeout=%0b running=%0b pending=%02h chan=%0b count=%08h",
                   words_out, exp_w.timeout, exp_w.running, exp_w.pending_mask,
                   exp_w.channel_pending, exp_w.count_value);
          $display("       got      timeout=%0b running=%0b pending=%02h chan=%0b count=%08h",
                   got.timeout, got.running, got.pending_mask, got.channel_pending,
                   got.count_value);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  wdr_in_if  req_if ();
  wdr_out_if rsp_if ();
  wdr_cfg_if cfg_if ();

  watchdog_multi_reload dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  wdog_scoreboard sb = new();

  result_t got_word;
  int      stall_pct = 20;
  int      rx_cycles = 0;
  int      hold_left = 0;
  bit      hold_req  = 1'b0;
  int      holds_done = 0;
  int      quiet = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: checks results, stalls randomly and serves long hold-off requests
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got_word.timeout         = rsp_if.timeout;
        got_word.running         = rsp_if.running;
        got_word.pending_mask    = rsp_if.pending_mask;
        got_word.channel_pending = rsp_if.channel_pending;
        got_word.count_value     = rsp_if.count_value;
        sb.check_result(got_word);
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
      // new stall density at intervals kept by rx_cycles, zero now and then
      rx_cycles++;
      if (rx_cycles % 256 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
    end
  end

  // Progress watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one word and hold it until accepted; valid stays high on return
  task automatic send_item(input func_t f, input logic [CHAN_W-1:0] ch,
                           input logic [COUNT_W-1:0] w, input logic sl, input logic ha);
    req_if.valid        <= 1'b1;
    req_if.func         <= f;
    req_if.channel      <= ch;
    req_if.write_word   <= w;
    req_if.cpu_sleeping <= sl;
    req_if.cpu_halted   <= ha;
    do @(posedge clk); while (!req_if.ready);
    sb.note_item(f, ch, w, sl, ha);
  endtask

  task automatic pause(input int n);
    req_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [COUNT_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, d);
  endtask

  // Write all registers plus the unused index; upper data bits carry noise
  task automatic configure(input logic [COUNT_W-1:0] rv, input logic [MASK_W-1:0] en,
                           input logic [MODE_W-1:0] md);
    logic [COUNT_W-1:0] noise;
    noise = $urandom;
    write_reg(REG_RELOAD_VALUE, rv);
    write_reg(REG_CHANNEL_ENABLE, {noise[COUNT_W-1:MASK_W], en});
    write_reg(REG_RUN_MODES, {noise[COUNT_W-1:MODE_W], md});
    write_reg(REG_UNUSED, $urandom);
    cfg_if.valid <= 1'b0;
  endtask

  // One random word; feeds mostly carry the magic word to an enabled channel
  task automatic random_item(input int tick_pct);
    int                 roll;
    func_t              f;
    logic [CHAN_W-1:0]  ch;
    logic [COUNT_W-1:0] w;
    logic               sl;
    logic               ha;
    roll = $urandom_range(0, 99);
    ch   = CHAN_W'($urandom_range(0, 15));
    w    = $urandom;
    sl   = ($urandom_range(0, 3) == 0);
    ha   = ($urandom_range(0, 3) == 0);
    if (roll < tick_pct) begin
      f = FUNC_TICK;
    end else if (roll < tick_pct + (100 - tick_pct) * 6 / 10) begin
      f = FUNC_FEED;
      if ($urandom_range(0, 9) < 8) begin
        w = FEED_MAGIC;
        if ((sb.enable_bits & CHAN_MASK) != 0 && $urandom_range(0, 9) < 8) begin
          do ch = CHAN_W'($urandom_range(0, CHANNELS - 1)); while (!sb.enable_bits[ch[2:0]]);
        end
      end
    end else if (roll < 96) begin
      f = FUNC_STATUS;
    end else begin
      f = FUNC_START;
    end
    send_item(f, ch, w, sl, ha);
  endtask

  // Main sequence
  initial begin
    int n;
    int burst;
    int tick_pct;
    bit hold_sent;
    bit drain_sent;
    n = 0;
    hold_sent = 1'b0;
    drain_sent = 1'b0;
    rst <= 1'b1;
    req_if.valid        <= 1'b0;
    req_if.func         <= FUNC_TICK;
    req_if.channel      <= '0;
    req_if.write_word   <= '0;
    req_if.cpu_sleeping <= 1'b0;
    req_if.cpu_halted   <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_RELOAD_VALUE;
    cfg_if.data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Stopped: register extremes, ticks and feeds have no effect
    configure('0, '0, '0);
    send_item(FUNC_TICK, 4'd0, '0, 1'b1, 1'b1);
    send_item(FUNC_FEED, 4'd0, FEED_MAGIC, 1'b0, 1'b0);
    wait_drained();
    configure('1, '1, '1);
    send_item(FUNC_STATUS, 4'd15, '1, 1'b1, 1'b1);
    send_item(FUNC_TICK, 4'd0, '0, 1'b0, 1'b0);
    wait_drained();

    // Setting kept for the running part: short reload so timeouts happen
    configure($urandom_range(2, 12), MASK_W'($urandom_range(1, 255)),
              MODE_W'($urandom_range(0, 15)));

    // Start, repeated start, ticks in every paused state
    send_item(FUNC_START, 4'd0, '0, 1'b0, 1'b0);
    send_item(FUNC_START, 4'd0, '0, 1'b0, 1'b0);
    send_item(FUNC_TICK, 4'd0, '0, 1'b0, 1'b0);
    send_item(FUNC_TICK, 4'd0, '0, 1'b1, 1'b0);
    send_item(FUNC_TICK, 4'd0, '0, 1'b0, 1'b1);
    send_item(FUNC_TICK, 4'd0, '0, 1'b1, 1'b1);
    // Bad feeds: wrong words, channels out of range
    send_item(FUNC_FEED, 4'd0, '0, 1'b0, 1'b0);
    send_item(FUNC_FEED, 4'd0, '1, 1'b0, 1'b0);
    send_item(FUNC_FEED, 4'd8, FEED_MAGIC, 1'b0, 1'b0);
    send_item(FUNC_FEED, 4'd15, FEED_MAGIC, 1'b0, 1'b0);
    // Feed every channel: disabled ones ignored, last enabled one reloads
    for (int c = 0; c < CHANNELS; c++)
      send_item(FUNC_FEED, CHAN_W'(c), FEED_MAGIC, 1'b0, 1'b0);
    send_item(FUNC_STATUS, 4'd0, '0, 1'b0, 1'b0);
    send_item(FUNC_STATUS, 4'd7, '0, 1'b0, 1'b0);
    send_item(FUNC_STATUS, 4'd8, '0, 1'b0, 1'b0);
    send_item(FUNC_STATUS, 4'd15, '0, 1'b0, 1'b0);

    // Random bursts, each randomly a tick-heavy or feed-heavy mix
    while (n < RANDOM_WORDS) begin
      burst = $urandom_range(1, 40);
      tick_pct = $urandom_range(0, 1) ? 85 : 30;
      if (!hold_sent && n >= 250) begin
        // receiver holds off while a full burst keeps coming
        hold_req = 1'b1;
        hold_sent = 1'b1;
        burst = 40;
        tick_pct = 50;
      end
      if (!drain_sent && n >= 500) begin
        // full drain, then register writes that the lock must ignore
        wait_drained();
        configure($urandom, MASK_W'($urandom), MODE_W'($urandom));
        drain_sent = 1'b1;
      end
      repeat (burst) begin
        random_item(tick_pct);
        n++;
      end
      if ($urandom_range(0, 2) != 0)
        pause($urandom_range(1, 10));
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d words and %0d register writes: %0d timeouts, %0d feed reloads.",
             sb.words_in, sb.reg_writes, sb.timeouts, sb.feed_reloads);
    $display("Results checked: %0d, long receiver hold-offs: %0d, mismatches: %0d.",
             sb.words_out, holds_done, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
